>>> src/ogbd_pkg.sv
// Shared types and constants for the occupancy grid block downsampler.
package ogbd_pkg;

  // Widths of the configuration registers and of the result fields
  localparam int unsigned ThreshW   = 8;
  localparam int unsigned NodeRegW  = 7;
  localparam int unsigned MapRegW   = 13;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CostW     = 8;
  localparam int unsigned BlkW      = 12;
  localparam int unsigned RowW      = 12;

  // Largest row count the design accepts and largest column count the map registers can hold
  localparam int unsigned RowLimit  = 4096;
  localparam int unsigned ColRegMax = 8191;

  // Reset values of the configuration registers
  localparam logic [ThreshW-1:0]  ThreshRst = 8'd253;
  localparam logic [NodeRegW-1:0] NodeRst   = 7'd1;
  localparam logic [MapRegW-1:0]  ColsRst   = 13'd1024;
  localparam logic [MapRegW-1:0]  RowsRst   = 13'd1024;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COST_THRESHOLD = 3'd0,
    REG_NODE_SIZE      = 3'd1,
    REG_MAP_COLS       = 3'd2,
    REG_MAP_ROWS       = 3'd3
  } cfg_reg_e;

  // Position of one accepted cell, as seen by the flag update stage
  typedef struct packed {
    logic            first;
    logic            emit;
    logic            map_end;
    logic [BlkW-1:0] block_col;
    logic [BlkW-1:0] block_row;
  } cell_pos_t;

endpackage

>>> src/ogbd_if.sv
// Valid/ready channel interfaces for cell words and block result words.
interface ogbd_in_if;
  logic                      valid;
  logic                      ready;
  logic [ogbd_pkg::CostW-1:0] cell_cost;

  modport source (output valid, output cell_cost, input ready);
  modport sink   (input valid, input cell_cost, output ready);
endinterface

interface ogbd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      occupied;
  logic [ogbd_pkg::BlkW-1:0] block_col;
  logic [ogbd_pkg::BlkW-1:0] block_row;
  logic                      end_of_map;

  modport source (output valid, output occupied, output block_col, output block_row,
                  output end_of_map, input ready);
  modport sink   (input valid, input occupied, input block_col, input block_row,
                  input end_of_map, output ready);
endinterface

>>> src/ogbd_flag_mem.sv
// Line store with one running occupancy flag per block column.
module ogbd_flag_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  output logic             rdata_o
);

  logic mem_q [Depth];
  logic rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ogbd_pos.sv
// Raster position counters that locate each incoming cell within its block.
module ogbd_pos #(
  parameter int unsigned ColW  = 12,
  parameter int unsigned NodeW = 6,
  parameter int unsigned CmpW  = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic                         restart_i,
  input  logic [CmpW-1:0]              node_i,
  input  logic [ogbd_pkg::MapRegW-1:0] cols_i,
  input  logic [ogbd_pkg::MapRegW-1:0] rows_i,
  output ogbd_pkg::cell_pos_t          pos_o,
  output logic [ColW-1:0]              slot_o
);

  import ogbd_pkg::*;

  logic [ColW-1:0]  cell_col_q, cell_col_d;
  logic [ColW-1:0]  blk_col_q, blk_col_d;
  logic [RowW-1:0]  cell_row_q, cell_row_d;
  logic [RowW-1:0]  blk_row_q, blk_row_d;
  logic [NodeW-1:0] cib_q, cib_d;
  logic [NodeW-1:0] rib_q, rib_d;
  logic             row_end, last_row, map_end, col_blk_end, row_blk_end;

  // Edge tests for the current cell
  always_comb begin
    row_end     = (MapRegW'(cell_col_q) + MapRegW'(1)) >= cols_i;
    last_row    = (MapRegW'(cell_row_q) + MapRegW'(1)) >= rows_i;
    map_end     = row_end && last_row;
    col_blk_end = ((CmpW'(cib_q) + CmpW'(1)) >= node_i) || row_end;
    row_blk_end = ((CmpW'(rib_q) + CmpW'(1)) >= node_i) || last_row;
  end

  // Next position in raster order
  always_comb begin
    cell_col_d = cell_col_q;
    blk_col_d  = blk_col_q;
    cell_row_d = cell_row_q;
    blk_row_d  = blk_row_q;
    cib_d      = cib_q;
    rib_d      = rib_q;
    if (restart_i || (advance_i && map_end)) begin
      cell_col_d = '0;
      blk_col_d  = '0;
      cell_row_d = '0;
      blk_row_d  = '0;
      cib_d      = '0;
      rib_d      = '0;
    end else if (advance_i && row_end) begin
      cell_col_d = '0;
      blk_col_d  = '0;
      cib_d      = '0;
      cell_row_d = cell_row_q + RowW'(1);
      if (row_blk_end) begin
        rib_d     = '0;
        blk_row_d = blk_row_q + RowW'(1);
      end else begin
        rib_d = rib_q + NodeW'(1);
      end
    end else if (advance_i) begin
      cell_col_d = cell_col_q + ColW'(1);
      if (col_blk_end) begin
        cib_d     = '0;
        blk_col_d = blk_col_q + ColW'(1);
      end else begin
        cib_d = cib_q + NodeW'(1);
      end
    end
  end

  // Position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_col_q <= '0;
      blk_col_q  <= '0;
      cell_row_q <= '0;
      blk_row_q  <= '0;
      cib_q      <= '0;
      rib_q      <= '0;
    end else begin
      cell_col_q <= cell_col_d;
      blk_col_q  <= blk_col_d;
      cell_row_q <= cell_row_d;
      blk_row_q  <= blk_row_d;
      cib_q      <= cib_d;
      rib_q      <= rib_d;
    end
  end

  // Description of the current cell for the flag stage
  always_comb begin
    pos_o.first     = (cib_q == '0) && (rib_q == '0);
    pos_o.emit      = col_blk_end && row_blk_end;
    pos_o.map_end   = map_end;
    pos_o.block_col = BlkW'(blk_col_q);
    pos_o.block_row = blk_row_q;
    slot_o          = blk_col_q;
  end

endmodule

>>> src/occupancy_grid_block_downsampler.sv
// Top level of the occupancy grid block downsampler.
//
// Cost-map cells enter on cell_i, one word per cell in raster order, row 0
// first. The map is cut into node_size by node_size blocks; blocks cut short
// by the right or bottom edge are kept. After the last cell of a block, one
// word leaves on block_o with the block's occupancy flag, its column and row
// and an end-of-map mark on the last block. The position counters then wrap
// for the next map.
// One cell is taken every cycle while the flag stage can move. A result word
// passes the flag stage and then the output register: the clock edge that
// takes the cell closing its block loads the flag stage, which reads and
// rewrites the per-column flag line store, and the output register takes the
// word once it is free. When block_o stalls, the flag stage and cell_i stop
// only once a finished block word waits both in the output register and behind it.
// Reset sets the registers to their defaults and the position to the map
// origin; the line store needs no clearing, since each block writes its flag
// on its first cell. Writing a known register index also restarts the map.
module occupancy_grid_block_downsampler #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned MAX_NODE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ogbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ogbd_pkg::CfgDataW-1:0] cfg_data_i,
  ogbd_in_if.sink                       cell_i,
  ogbd_out_if.source                    block_o
);

  import ogbd_pkg::*;

  localparam int unsigned MaxColsEff = (MAX_COLS < ColRegMax) ? MAX_COLS : ColRegMax;
  localparam int unsigned ColW       = $clog2(MaxColsEff);
  localparam int unsigned AddrW      = $clog2(MAX_COLS);
  localparam int unsigned NodeW      = $clog2(MAX_NODE);
  localparam int unsigned CmpW       = (NodeW + 1 > NodeRegW) ? NodeW + 1 : NodeRegW;

  // Configuration registers
  logic [ThreshW-1:0]  thresh_q;
  logic [NodeRegW-1:0] node_q;
  logic [MapRegW-1:0]  cols_q;
  logic [MapRegW-1:0]  rows_q;
  logic                restart;

  // Clamped limits
  logic [CmpW-1:0]     node_raw, node_eff;
  logic [MapRegW-1:0]  cols_eff, rows_eff;

  // Flag stage and output register
  cell_pos_t           pos, s1_pos_q;
  logic [ColW-1:0]     slot, s1_slot_q;
  logic [CostW-1:0]    s1_cost_q;
  logic                s1_valid_q;
  logic                fwd_q, fwd_val_q;
  logic                mem_rd, prev_flag, s1_flag, s1_fire, s1_adv, in_fire, out_free;
  logic                out_valid_q, out_occ_q, out_eom_q;
  logic [BlkW-1:0]     out_col_q, out_row_q;

  // Register write decoder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshRst;
      node_q   <= NodeRst;
      cols_q   <= ColsRst;
      rows_q   <= RowsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COST_THRESHOLD: thresh_q <= ThreshW'(cfg_data_i);
        REG_NODE_SIZE:      node_q   <= NodeRegW'(cfg_data_i);
        REG_MAP_COLS:       cols_q   <= cfg_data_i;
        REG_MAP_ROWS:       rows_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A write to any known register restarts the map
  always_comb begin
    unique case (cfg_reg_e'(cfg_idx_i))
      REG_COST_THRESHOLD, REG_NODE_SIZE, REG_MAP_COLS, REG_MAP_ROWS: restart = cfg_we_i;
      default: restart = 1'b0;
    endcase
  end

  // Zero sizes act as one; oversized values are held to the design limits
  always_comb begin
    node_raw = CmpW'(node_q);
    if (node_raw == '0) begin
      node_eff = CmpW'(1);
    end else if (node_raw > CmpW'(MAX_NODE)) begin
      node_eff = CmpW'(MAX_NODE);
    end else begin
      node_eff = node_raw;
    end
    if (cols_q == '0) begin
      cols_eff = MapRegW'(1);
    end else if (cols_q > MapRegW'(MaxColsEff)) begin
      cols_eff = MapRegW'(MaxColsEff);
    end else begin
      cols_eff = cols_q;
    end
    if (rows_q == '0) begin
      rows_eff = MapRegW'(1);
    end else if (rows_q > MapRegW'(RowLimit)) begin
      rows_eff = MapRegW'(RowLimit);
    end else begin
      rows_eff = rows_q;
    end
  end

  // Handshake: the flag stage moves unless its finished block word finds the output full
  assign out_free      = !out_valid_q || block_o.ready;
  assign s1_adv        = !s1_valid_q || !s1_pos_q.emit || out_free;
  assign s1_fire       = s1_valid_q && s1_adv;
  assign cell_i.ready  = s1_adv;
  assign in_fire       = cell_i.valid && s1_adv;

  ogbd_pos #(
    .ColW  (ColW),
    .NodeW (NodeW),
    .CmpW  (CmpW)
  ) u_pos (
    .clk_i,
    .rst_ni,
    .advance_i (in_fire),
    .restart_i (restart),
    .node_i    (node_eff),
    .cols_i    (cols_eff),
    .rows_i    (rows_eff),
    .pos_o     (pos),
    .slot_o    (slot)
  );

  ogbd_flag_mem #(
    .Depth (MAX_COLS),
    .AddrW (AddrW)
  ) u_flag_mem (
    .clk_i,
    .re_i    (in_fire),
    .raddr_i (AddrW'(slot)),
    .we_i    (s1_fire),
    .waddr_i (AddrW'(s1_slot_q)),
    .wdata_i (s1_flag),
    .rdata_o (mem_rd)
  );

  // Input register of the flag stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= cell_i.valid;
      if (cell_i.valid) begin
        fwd_q <= s1_fire && (s1_slot_q == slot);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cost_q <= cell_i.cell_cost;
      s1_pos_q  <= pos;
      s1_slot_q <= slot;
      fwd_val_q <= s1_flag;
    end
  end

  // Flag update: a write to the same column in the read cycle is forwarded
  always_comb begin
    prev_flag = fwd_q ? fwd_val_q : mem_rd;
    if (s1_pos_q.first) begin
      s1_flag = s1_cost_q > thresh_q;
    end else begin
      s1_flag = prev_flag || (s1_cost_q > thresh_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && s1_pos_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_fire && s1_pos_q.emit) begin
      out_occ_q <= s1_flag;
      out_col_q <= s1_pos_q.block_col;
      out_row_q <= s1_pos_q.block_row;
      out_eom_q <= s1_pos_q.map_end;
    end
  end

  assign block_o.valid      = out_valid_q;
  assign block_o.occupied   = out_occ_q;
  assign block_o.block_col  = out_col_q;
  assign block_o.block_row  = out_row_q;
  assign block_o.end_of_map = out_eom_q;

endmodule
